@@ rtl/core/csfd_pkg.sv @@
// shared types and constants for the serial CAN frame deframer
// no dependencies; imported by csfd_core, csfd_checker and can_serial_frame_deframer_top

package csfd_pkg;

  // framing bytes and type byte masks
  localparam logic [7:0] START_BYTE   = 8'hAA;
  localparam logic [7:0] END_BYTE     = 8'h55;
  localparam logic [7:0] TYPE_MARK    = 8'hC0;
  localparam logic [7:0] EXT_TOP_MASK = 8'h1F;
  localparam logic [7:0] STD_TOP_MASK = 8'h07;
  localparam logic [7:0] DLC_MASK     = 8'h0F;
  localparam logic [3:0] MAX_DLC      = 4'd8;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_TYPE = 3'd1;
  localparam logic [2:0] ST_BAD_DLC  = 3'd2;
  localparam logic [2:0] ST_NO_END   = 3'd3;
  localparam logic [2:0] ST_TIMEOUT  = 3'd4;

  // frame phase, one-hot
  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_TYPE = 4'b0010,
    PH_ID   = 4'b0100,
    PH_BODY = 4'b1000
  } phase_e;

  // one result beat
  typedef struct packed {
    logic [2:0]  status;
    logic        is_extended;
    logic        is_remote;
    logic [3:0]  length_code;
    logic [28:0] frame_id;
    logic [63:0] payload;
  } result_t;

endpackage

@@ rtl/core/can_serial_frame_deframer_top.sv @@
// top level of the serial CAN frame deframer: input register, frame logic,
// result register; depends on csfd_pkg and csfd_core

// Rebuilds CAN frames from a serial adapter byte stream (0xAA, type, id, data,
// 0x55) and gives one result beat per finished or failed frame. Each input beat
// is one byte or a timeout flag. It is registered and passes the frame state
// machine in a cycle when the result register is free or being drained; any
// result is captured in the output register at the end of that cycle and
// offered in the cycle after. A byte can be accepted every cycle while results
// are taken. The input register holds one byte while a result waits, so input
// stalls only when both are full.
module can_serial_frame_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        timed_out_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic        is_extended_o,
  output logic        is_remote_o,
  output logic [3:0]  length_code_o,
  output logic [28:0] frame_id_o,
  output logic [63:0] payload_o
);
  import csfd_pkg::*;

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       to_q;
  logic       step;
  logic       res_valid;
  result_t    res;
  logic       out_valid_q;
  result_t    out_q;

  // the held byte moves on when the result slot is free or being drained
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
      to_q   <= timed_out_i;
    end
  end

  csfd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .rx_byte_i   (byte_q),
    .timed_out_i (to_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign is_extended_o = out_q.is_extended;
  assign is_remote_o   = out_q.is_remote;
  assign length_code_o = out_q.length_code;
  assign frame_id_o    = out_q.frame_id;
  assign payload_o     = out_q.payload;

endmodule

@@ rtl/core/csfd_core.sv @@
// frame state machine: consumes one byte per step and flags a finished or failed frame
// depends on csfd_pkg

module csfd_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             timed_out_i,
  output logic             res_valid_o,
  output csfd_pkg::result_t res_o
);
  import csfd_pkg::*;

  phase_e      phase_q, phase_d;
  logic        ext_q, ext_d;
  logic        rtr_q, rtr_d;
  logic [3:0]  dlc_q, dlc_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [28:0] id_q, id_d;
  logic [63:0] pay_q, pay_d;

  logic [1:0]  id_idx;
  logic [1:0]  id_last;
  logic [7:0]  id_byte;
  logic [31:0] id_shift;
  logic [3:0]  frame_len;
  logic [63:0] pay_shift;

  // identifier lane and payload lane helpers
  assign id_idx    = cnt_q[1:0];
  assign id_last   = ext_q ? 2'd3 : 2'd1;
  assign id_byte   = (id_idx == id_last) ?
                     (rx_byte_i & (ext_q ? EXT_TOP_MASK : STD_TOP_MASK)) : rx_byte_i;
  assign id_shift  = {24'd0, id_byte} << {id_idx, 3'b000};
  assign frame_len = rtr_q ? 4'd0 : dlc_q;
  assign pay_shift = {56'd0, rx_byte_i} << {cnt_q[2:0], 3'b000};

  // next state and result
  always_comb begin
    phase_d     = phase_q;
    ext_d       = ext_q;
    rtr_d       = rtr_q;
    dlc_d       = dlc_q;
    cnt_d       = cnt_q;
    id_d        = id_q;
    pay_d       = pay_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (phase_q)
      PH_HUNT: begin
        if (!timed_out_i && rx_byte_i == START_BYTE) phase_d = PH_TYPE;
      end
      PH_TYPE: begin
        if (timed_out_i) begin
          res_valid_o = 1'b1;
          res_o.status = ST_TIMEOUT;
          phase_d = PH_HUNT;
        end else if ((rx_byte_i & TYPE_MARK) != TYPE_MARK) begin
          res_valid_o = 1'b1;
          res_o.status = ST_BAD_TYPE;
          phase_d = PH_HUNT;
        end else if (rx_byte_i[3:0] > MAX_DLC) begin
          res_valid_o = 1'b1;
          res_o.status = ST_BAD_DLC;
          phase_d = PH_HUNT;
        end else begin
          ext_d   = rx_byte_i[5];
          rtr_d   = rx_byte_i[4];
          dlc_d   = rx_byte_i[3:0];
          cnt_d   = 4'd0;
          id_d    = '0;
          pay_d   = '0;
          phase_d = PH_ID;
        end
      end
      PH_ID: begin
        if (timed_out_i) begin
          res_valid_o = 1'b1;
          res_o.status = ST_TIMEOUT;
          phase_d = PH_HUNT;
        end else begin
          id_d = id_q | id_shift[28:0];
          if (id_idx == id_last) begin
            cnt_d   = 4'd0;
            phase_d = PH_BODY;
          end else begin
            cnt_d = {2'b00, id_idx + 2'd1};
          end
        end
      end
      PH_BODY: begin
        if (timed_out_i) begin
          res_valid_o = 1'b1;
          res_o.status = ST_TIMEOUT;
          phase_d = PH_HUNT;
        end else if (cnt_q < frame_len) begin
          pay_d = pay_q | pay_shift;
          cnt_d = cnt_q + 4'd1;
        end else if (rx_byte_i != END_BYTE) begin
          res_valid_o = 1'b1;
          res_o.status = ST_NO_END;
          phase_d = PH_HUNT;
        end else begin
          res_valid_o       = 1'b1;
          res_o.status      = ST_OK;
          res_o.is_extended = ext_q;
          res_o.is_remote   = rtr_q;
          res_o.length_code = dlc_q;
          res_o.frame_id    = id_q;
          res_o.payload     = pay_q;
          phase_d           = PH_HUNT;
        end
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  // state registers, advance only on an accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      ext_q   <= 1'b0;
      rtr_q   <= 1'b0;
      dlc_q   <= 4'd0;
      cnt_q   <= 4'd0;
      id_q    <= '0;
      pay_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      ext_q   <= ext_d;
      rtr_q   <= rtr_d;
      dlc_q   <= dlc_d;
      cnt_q   <= cnt_d;
      id_q    <= id_d;
      pay_q   <= pay_d;
    end
  end

endmodule

@@ rtl/core/csfd_checker.sv @@
// port-level checks for the serial CAN frame deframer, bound to the top level
// depends on csfd_pkg and can_serial_frame_deframer_top

module csfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic        is_extended_o,
  input logic        is_remote_o,
  input logic [3:0]  length_code_o,
  input logic [28:0] frame_id_o,
  input logic [63:0] payload_o
);
  import csfd_pkg::*;

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(payload_o))
    else $error("result beat changed while stalled");

  // failed frames carry only a status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |->
      !is_extended_o && !is_remote_o && length_code_o == 4'd0 &&
      frame_id_o == 29'd0 && payload_o == 64'd0)
    else $error("failed frame with nonzero fields");

  // good frames: dlc in range, remote frames empty, standard id fits 11 bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK |->
      length_code_o <= MAX_DLC && (!is_remote_o || payload_o == 64'd0) &&
      (is_extended_o || frame_id_o[28:11] == 18'd0))
    else $error("inconsistent good frame");

  // status stays within the defined codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_TIMEOUT)
    else $error("undefined status code");

endmodule

bind can_serial_frame_deframer_top csfd_checker u_csfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .is_extended_o (is_extended_o),
  .is_remote_o   (is_remote_o),
  .length_code_o (length_code_o),
  .frame_id_o    (frame_id_o),
  .payload_o     (payload_o)
);
